[hdl/gfd_pkg.sv]
// ----------------------------------------------------------------------------
// Grid finite difference gradient: shared definitions
// Field widths, register indexes, item kinds and the edge-flag struct used by
// the gradient block and its difference units.
// ----------------------------------------------------------------------------
package gfd_pkg;

    // Default sizing of the mesh and of the coordinates.
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_COORD_BITS = 24;

    // Result field widths.
    localparam int DERIV_W   = 26;
    localparam int POS_W     = 10;
    localparam int M_TDATA_W = 6 * DERIV_W + 2 * POS_W;

    // Configuration port.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    // Mesh size after reset.
    localparam int RESET_DIM = 2;

    // Item kinds carried in s_tuser.
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Position of a point along one axis of the mesh.
    typedef struct packed {
        logic first;  // first point on this axis
        logic last;   // last point on this axis
        logic zero;   // the axis has a single point
    } gfd_axis_t;

endpackage

[hdl/gfd_line_store.sv]
// ----------------------------------------------------------------------------
// Grid finite difference gradient: three-row line store
// Holds three mesh rows of packed x/y/z points. One write port and two read
// ports with registered read data; a read of the address written in the same
// cycle returns the new data.
// ----------------------------------------------------------------------------
module gfd_line_store
    import gfd_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_COLS   = DEF_MAX_COLS
) (
    input  logic                          aclk,
    input  logic                          we_i,
    input  logic [$clog2(MAX_COLS)+1:0]   waddr_i,
    input  logic [3*COORD_BITS-1:0]       wdata_i,
    input  logic                          re_i,
    input  logic [$clog2(MAX_COLS)+1:0]   raddr_a_i,
    input  logic [$clog2(MAX_COLS)+1:0]   raddr_b_i,
    output logic [3*COORD_BITS-1:0]       rdata_a_o,
    output logic [3*COORD_BITS-1:0]       rdata_b_o
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int DEPTH = 3 * (2 ** CW);

    // Row slot in the upper two address bits, column below.
    logic [3*COORD_BITS-1:0] mem [0:DEPTH-1];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[waddr_i] <= wdata_i;
        end
    end

    // Read ports with write-through on an address match.
    always_ff @(posedge aclk) begin
        if (re_i) begin
            if (we_i && (raddr_a_i == waddr_i)) begin
                rdata_a_o <= wdata_i;
            end else begin
                rdata_a_o <= mem[raddr_a_i];
            end
            if (we_i && (raddr_b_i == waddr_i)) begin
                rdata_b_o <= wdata_i;
            end else begin
                rdata_b_o <= mem[raddr_b_i];
            end
        end
    end

endmodule

[hdl/gfd_diff.sv]
// ----------------------------------------------------------------------------
// Grid finite difference gradient: one-axis difference unit
// Central difference in the interior, doubled one-sided difference at the
// edges, zero on an axis of one point. Inputs carry 8 fraction bits, the
// result 9, so the halving of the central difference costs nothing.
// ----------------------------------------------------------------------------
module gfd_diff
    import gfd_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic signed [COORD_BITS-1:0] prv_i,
    input  logic signed [COORD_BITS-1:0] cur_i,
    input  logic signed [COORD_BITS-1:0] nxt_i,
    input  gfd_axis_t                    axis_i,
    output logic signed [DERIV_W-1:0]    deriv_o
);

    logic signed [COORD_BITS:0]   minuend;
    logic signed [COORD_BITS:0]   subtrahend;
    logic signed [COORD_BITS:0]   diff;
    logic signed [COORD_BITS+1:0] scaled;

    // Pick the operands: the current point stands in for a missing neighbor.
    assign minuend    = axis_i.last  ? (COORD_BITS+1)'(cur_i) : (COORD_BITS+1)'(nxt_i);
    assign subtrahend = axis_i.first ? (COORD_BITS+1)'(cur_i) : (COORD_BITS+1)'(prv_i);
    assign diff       = minuend - subtrahend;

    // One-sided differences are doubled to match the 9 fraction bits.
    assign scaled = (axis_i.first || axis_i.last) ? {diff, 1'b0} : (COORD_BITS+2)'(diff);

    assign deriv_o = axis_i.zero ? '0 : DERIV_W'(scaled);

endmodule

[hdl/grid_finite_difference_gradient.sv]
// ----------------------------------------------------------------------------
// Grid finite difference gradient
// Points of a row-by-column mesh enter in raster order on the s_ channel
// (s_tuser = OP_POINT). For each point the block returns the derivative along
// the columns and along the rows on the m_ channel. The result for row r-1,
// column c leaves after point (r, c) has arrived; once every point is in,
// one drain item (s_tuser = OP_DRAIN) per column flushes the last row. Points
// beyond rows*cols and drains that are early or surplus give no result.
// m_tlast marks the result of the mesh's final point.
// Mesh size is set through the cfg_ port (index 0 rows, index 1 columns);
// a write to either index restarts the mesh counters and is to be made by
// the user while the block is idle; the block itself does not enforce this.
// Timing: one item per cycle sustained while the receiver keeps up. The
// accepting edge loads the input register and the line store read, and the
// output register takes the result from them when it is free. The line
// store has one write and two read ports, which is what a row pass needs
// per point, so no item waits on memory. Reset clears the counters and sets
// a 2 by 2 mesh; the line store is not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its item, one more
// item waits in the input stage, and then s_tready drops.
// ----------------------------------------------------------------------------
module grid_finite_difference_gradient
    import gfd_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: px, py, pz (COORD_BITS each), zero fill to bytes
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // s_tuser: op (OP_POINT or OP_DRAIN)
    input  logic [0:0]                          s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: ds_x, ds_y, ds_z, dt_x, dt_y, dt_z, out_row, out_col
    output logic [M_TDATA_W-1:0]                m_tdata,
    // m_tlast: mesh_done
    output logic                                m_tlast,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_W-1:0]                    cfg_data
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int DCW  = $clog2(MAX_COLS + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int AW   = CW + 2;
    localparam int PT_W = 3 * COORD_BITS;

    // ------------------------------------------------------------------
    // Configuration and mesh counters
    // ------------------------------------------------------------------
    logic [RW-1:0]  num_rows_reg, num_rows_next;
    logic [DCW-1:0] num_cols_reg, num_cols_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [DCW-1:0] drain_col_reg, drain_col_next;
    logic [1:0]     slot_reg, slot_next;
    logic [RW-1:0]  cfg_rows;
    logic [DCW-1:0] cfg_cols;
    logic           cfg_write;

    logic           s_accept;
    logic           is_point;
    logic           point_ok;
    logic           drain_ok;
    logic           item_active;
    logic           item_emit;
    logic           col_at_end;
    logic [CW-1:0]  item_col;
    logic [RW-1:0]  item_row;
    logic [1:0]     slot_prev;
    logic [1:0]     slot_prev2;
    gfd_axis_t      col_axis;
    gfd_axis_t      row_axis;

    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr_a;
    logic [AW-1:0]  raddr_b;
    logic           store_we;
    logic [PT_W-1:0] rd_a;
    logic [PT_W-1:0] rd_b;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_accept  = s_tvalid && s_tready;

    // Clamp written dimensions to 1..MAX.
    always_comb begin
        if (cfg_data == '0) begin
            cfg_rows = RW'(1);
            cfg_cols = DCW'(1);
        end else begin
            if (int'(cfg_data) > MAX_ROWS) begin
                cfg_rows = RW'(MAX_ROWS);
            end else begin
                cfg_rows = RW'(cfg_data);
            end
            if (int'(cfg_data) > MAX_COLS) begin
                cfg_cols = DCW'(MAX_COLS);
            end else begin
                cfg_cols = DCW'(cfg_data);
            end
        end
    end

    // Classify the offered item and work out its position and store addresses.
    always_comb begin
        is_point    = (s_tuser[0] == OP_POINT);
        point_ok    = is_point && (in_row_reg < num_rows_reg);
        drain_ok    = !is_point && (in_row_reg >= num_rows_reg)
                      && (drain_col_reg < num_cols_reg);
        item_active = point_ok || drain_ok;
        item_emit   = drain_ok || (point_ok && (in_row_reg != '0));
        col_at_end  = (DCW'(in_col_reg) == num_cols_reg - DCW'(1));

        item_col = is_point ? in_col_reg : drain_col_reg[CW-1:0];
        item_row = is_point ? (in_row_reg - RW'(1)) : (num_rows_reg - RW'(1));

        slot_prev  = (slot_reg == 2'd0) ? 2'd2 : (slot_reg - 2'd1);
        slot_prev2 = (slot_reg == 2'd2) ? 2'd0 : (slot_reg + 2'd1);

        // At the end of a point row, prefetch the first column of that row.
        if (is_point && col_at_end) begin
            raddr_a = {slot_reg, CW'(0)};
        end else begin
            raddr_a = {slot_prev, item_col + CW'(1)};
        end
        raddr_b  = {slot_prev2, item_col};
        waddr    = {slot_reg, in_col_reg};
        store_we = s_accept && point_ok;

        col_axis.first = (item_col == '0);
        col_axis.last  = (DCW'(item_col) == num_cols_reg - DCW'(1));
        col_axis.zero  = (num_cols_reg == DCW'(1));
        row_axis.first = (item_row == '0);
        row_axis.last  = (item_row == num_rows_reg - RW'(1));
        row_axis.zero  = (num_rows_reg == RW'(1));
    end

    // Next state of the dimensions and counters.
    always_comb begin
        num_rows_next  = num_rows_reg;
        num_cols_next  = num_cols_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        drain_col_next = drain_col_reg;
        slot_next      = slot_reg;
        if (cfg_write) begin
            if (cfg_index == REG_NUM_ROWS) begin
                num_rows_next = cfg_rows;
            end
            if (cfg_index == REG_NUM_COLS) begin
                num_cols_next = cfg_cols;
            end
            if ((cfg_index == REG_NUM_ROWS) || (cfg_index == REG_NUM_COLS)) begin
                in_row_next    = '0;
                in_col_next    = '0;
                drain_col_next = '0;
                slot_next      = 2'd0;
            end
        end else if (s_accept && point_ok) begin
            if (col_at_end) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
                slot_next   = slot_prev2;
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
        end else if (s_accept && drain_ok) begin
            drain_col_next = drain_col_reg + DCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg  <= RW'(RESET_DIM);
            num_cols_reg  <= DCW'(RESET_DIM);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            drain_col_reg <= '0;
            slot_reg      <= 2'd0;
        end else begin
            num_rows_reg  <= num_rows_next;
            num_cols_reg  <= num_cols_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            drain_col_reg <= drain_col_next;
            slot_reg      <= slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    gfd_line_store #(
        .COORD_BITS (COORD_BITS),
        .MAX_COLS   (MAX_COLS)
    ) u_line_store (
        .aclk      (aclk),
        .we_i      (store_we),
        .waddr_i   (waddr),
        .wdata_i   (s_tdata[PT_W-1:0]),
        .re_i      (s_accept),
        .raddr_a_i (raddr_a),
        .raddr_b_i (raddr_b),
        .rdata_a_o (rd_a),
        .rdata_b_o (rd_b)
    );

    // ------------------------------------------------------------------
    // Input stage: the accepted item next to its store reads
    // ------------------------------------------------------------------
    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic [RW-1:0]   s1_row_reg;
    logic [CW-1:0]   s1_col_reg;
    gfd_axis_t       s1_col_axis_reg;
    gfd_axis_t       s1_row_axis_reg;
    logic [PT_W-1:0] s1_dn_reg;
    logic            s1_advance;

    logic            out_valid_reg;
    logic            out_last_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic            out_load;

    assign s1_advance = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign out_load   = s1_advance && s1_emit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_accept && item_active;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_emit_reg     <= item_emit;
            s1_row_reg      <= item_row;
            s1_col_reg      <= item_col;
            s1_col_axis_reg <= col_axis;
            s1_row_axis_reg <= row_axis;
            s1_dn_reg       <= s_tdata[PT_W-1:0];
        end
    end

    // Window over the row being emitted: previous and current column.
    logic [PT_W-1:0] win_prev_reg;
    logic [PT_W-1:0] win_cur_reg;

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            win_prev_reg <= win_cur_reg;
            win_cur_reg  <= rd_a;
        end
    end

    // ------------------------------------------------------------------
    // Difference units, one per coordinate and axis
    // ------------------------------------------------------------------
    logic [2:0][DERIV_W-1:0] ds_vec;
    logic [2:0][DERIV_W-1:0] dt_vec;

    for (genvar k = 0; k < 3; k++) begin : g_coord
        gfd_diff #(
            .COORD_BITS (COORD_BITS)
        ) u_ds (
            .prv_i   (win_prev_reg[k*COORD_BITS +: COORD_BITS]),
            .cur_i   (win_cur_reg[k*COORD_BITS +: COORD_BITS]),
            .nxt_i   (rd_a[k*COORD_BITS +: COORD_BITS]),
            .axis_i  (s1_col_axis_reg),
            .deriv_o (ds_vec[k])
        );
        gfd_diff #(
            .COORD_BITS (COORD_BITS)
        ) u_dt (
            .prv_i   (rd_b[k*COORD_BITS +: COORD_BITS]),
            .cur_i   (win_cur_reg[k*COORD_BITS +: COORD_BITS]),
            .nxt_i   (s1_dn_reg[k*COORD_BITS +: COORD_BITS]),
            .axis_i  (s1_row_axis_reg),
            .deriv_o (dt_vec[k])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {POS_W'(s1_col_reg), POS_W'(s1_row_reg), dt_vec, ds_vec};
            out_last_reg <= s1_row_axis_reg.last && s1_col_axis_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The point column never runs past the configured width.
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        DCW'(in_col_reg) < num_cols_reg)
        else $error("point column counter beyond mesh width");

    // Row and drain counters stop at the mesh size.
    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_row_reg <= num_rows_reg) && (drain_col_reg <= num_cols_reg))
        else $error("row or drain counter beyond mesh size");

    // A held input stage keeps its item.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_advance) |=>
            (s1_valid_reg && $stable(s1_row_reg) && $stable(s1_col_reg)))
        else $error("input stage lost or changed a held item");

    // A full, stalled pipe refuses new items.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_emit_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("item accepted while both stages are held");

    // Drained results only once every point has arrived.
    a_drain_after_points: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && drain_ok) |-> (in_row_reg == num_rows_reg))
        else $error("drain served before the mesh was complete");

endmodule

[sim/tb_grid_finite_difference_gradient.sv]
// ----------------------------------------------------------------------------
// Testbench for the grid finite difference gradient block
// Streams meshes of points and drain items through the block and checks every
// result against a cycle-free predictor of the gradient. It starts with a
// short directed part on small meshes, then the first rows of a tall
// single-column mesh with a saturating row count, then many small random
// meshes. Points, drains and register writes are mixed with surplus and early
// items. Both stream sides idle at random except near the end of the run.
// ----------------------------------------------------------------------------
module tb_grid_finite_difference_gradient;
    import gfd_pkg::*;

    localparam int S_TDATA_W  = ((3 * DEF_COORD_BITS + 7) / 8) * 8;
    localparam int COORD_W    = DEF_COORD_BITS;
    localparam int STORE_COLS = DEF_MAX_COLS;
    localparam int IDLE_LIMIT = 1000;
    localparam int SETTLE_CYC = 4;
    localparam int FLUSH_CYC  = 8;
    localparam int RAND_ITEMS = 500;
    localparam int QUIET_FROM = 420;
    localparam int TALL_PTS   = 60;

    // Register indexes that select no register.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // One result item, laid out as {m_tlast, m_tdata}.
    typedef struct packed {
        logic               mesh_done;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [DERIV_W-1:0] dt_z;
        logic [DERIV_W-1:0] dt_y;
        logic [DERIV_W-1:0] dt_x;
        logic [DERIV_W-1:0] ds_z;
        logic [DERIV_W-1:0] ds_y;
        logic [DERIV_W-1:0] ds_x;
    } gradient_t;

    // Predicts the gradient of each point and checks the block's results.
    class gradient_checker;
        bit [S_TDATA_W-1:0] mesh_store [0:3*STORE_COLS-1];
        int unsigned        rows, cols, in_row, in_col, drain_col;
        gradient_t          grads_due[$];
        int unsigned        errors;

        function new();
            rows = RESET_DIM;
            cols = RESET_DIM;
            in_row = 0;
            in_col = 0;
            drain_col = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return grads_due.size();
        endfunction

        // Appends one predicted result to the results still due.
        function void queue_grad(gradient_t g);
            grads_due = {grads_due, g};
        endfunction

        function int unsigned clamp_dim(logic [CFG_W-1:0] val, int unsigned hi);
            if (val == 0) return 1;
            if (val > hi) return hi;
            return val;
        endfunction

        // A write to a real register also restarts the mesh counters.
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_NUM_ROWS: rows = clamp_dim(val, DEF_MAX_ROWS);
                REG_NUM_COLS: cols = clamp_dim(val, DEF_MAX_COLS);
                default: return;
            endcase
            in_row = 0;
            in_col = 0;
            drain_col = 0;
        endfunction

        function longint coord(int unsigned row, int unsigned col, int k);
            logic signed [COORD_W-1:0] v;
            v = mesh_store[(row % 3) * STORE_COLS + (col % STORE_COLS)][k*COORD_W +: COORD_W];
            return longint'(v);
        endfunction

        // One-sided difference doubled at an edge, plain central difference
        // inside; both land on 9 fraction bits.
        function logic [DERIV_W-1:0] partial_diff(int unsigned row, int unsigned col,
                                                  bit along_cols, int k);
            int unsigned n, i;
            longint here, ahead, behind, d;
            n = along_cols ? cols : rows;
            i = along_cols ? col : row;
            if (n <= 1) return '0;
            here = coord(row, col, k);
            behind = 0;
            ahead = 0;
            if (i != 0)
                behind = along_cols ? coord(row, col - 1, k) : coord(row - 1, col, k);
            if (i != n - 1)
                ahead = along_cols ? coord(row, col + 1, k) : coord(row + 1, col, k);
            if (i == 0) d = (ahead - here) * 2;
            else if (i == n - 1) d = (here - behind) * 2;
            else d = ahead - behind;
            return d[DERIV_W-1:0];
        endfunction

        function gradient_t gradient_at(int unsigned row, int unsigned col);
            gradient_t g;
            g.ds_x = partial_diff(row, col, 1'b1, 0);
            g.ds_y = partial_diff(row, col, 1'b1, 1);
            g.ds_z = partial_diff(row, col, 1'b1, 2);
            g.dt_x = partial_diff(row, col, 1'b0, 0);
            g.dt_y = partial_diff(row, col, 1'b0, 1);
            g.dt_z = partial_diff(row, col, 1'b0, 2);
            g.row = row[POS_W-1:0];
            g.col = col[POS_W-1:0];
            g.mesh_done = (row == rows - 1) && (col == cols - 1);
            return g;
        endfunction

        // Takes one accepted input item and queues the result it causes.
        function void take_item(logic op, logic [S_TDATA_W-1:0] pt);
            int unsigned r, c;
            if (op == OP_POINT) begin
                // Points past the end of the mesh are dropped.
                if (in_row >= rows) return;
                r = in_row;
                c = in_col;
                mesh_store[(r % 3) * STORE_COLS + (c % STORE_COLS)] = pt;
                if (c + 1 >= cols) begin
                    in_col = 0;
                    in_row = r + 1;
                end else begin
                    in_col = c + 1;
                end
                if (r != 0) queue_grad(gradient_at(r - 1, c));
            end else begin
                // A drain counts only after the last point, once per column.
                if (in_row < rows || drain_col >= cols) return;
                queue_grad(gradient_at(rows - 1, drain_col));
                drain_col++;
            end
        endfunction

        // Prints one line per mismatch and counts it.
        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task compare(string field, logic [DERIV_W-1:0] got, logic [DERIV_W-1:0] want,
                     gradient_t ref_pos);
            if (got !== want)
                report($sformatf("row %0d col %0d %s: got %h, want %h",
                                 ref_pos.row, ref_pos.col, field, got, want));
        endtask

        task check_result(gradient_t got);
            gradient_t want;
            if (grads_due.size() == 0) begin
                report($sformatf("result row %0d col %0d with none due", got.row, got.col));
                return;
            end
            want = grads_due.pop_front();
            compare("ds_x", got.ds_x, want.ds_x, want);
            compare("ds_y", got.ds_y, want.ds_y, want);
            compare("ds_z", got.ds_z, want.ds_z, want);
            compare("dt_x", got.dt_x, want.dt_x, want);
            compare("dt_y", got.dt_y, want.dt_y, want);
            compare("dt_z", got.dt_z, want.dt_z, want);
            compare("out_row", DERIV_W'(got.row), DERIV_W'(want.row), want);
            compare("out_col", DERIV_W'(got.col), DERIV_W'(want.col), want);
            compare("mesh_done", DERIV_W'(got.mesh_done), DERIV_W'(want.mesh_done), want);
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    gradient_checker        grad_check;
    bit                     quiet;
    int unsigned            rand_count;
    int unsigned            idle_cycles;

    grid_finite_difference_gradient dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Receiver: bursts of ready and stall, always ready near the end.
    initial begin
        m_tready = 1'b0;
        forever begin
            m_tready <= quiet || ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    end

    // Check every accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) grad_check.check_result({m_tlast, m_tdata});
    end

    // Watchdog on cycles in which no item moves on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_grid_finite_difference_gradient: done, errors");
            $finish;
        end
    end

    // Coordinates lean toward the extremes now and then.
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(COORD_W-1){1'b1}}};
            1: return {1'b1, {(COORD_W-1){1'b0}}};
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] rand_point();
        return {rand_coord(), rand_coord(), rand_coord()};
    endfunction

    // Send one item; valid stays high until someone lowers it for a gap.
    task automatic send_item(input logic op, input logic [S_TDATA_W-1:0] pt);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end else if (!quiet && grad_check.pending() != 0 && $urandom_range(0, 63) == 0) begin
            // Hold off until every result due so far has come out.
            s_tvalid <= 1'b0;
            while (grad_check.pending() != 0) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pt;
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
        grad_check.take_item(op, pt);
        rand_count++;
    endtask

    // Stop sending and let the block run empty before a register write.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (grad_check.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        grad_check.set_reg(idx, val);
    endtask

    task automatic configure(input bit set_rows, input logic [CFG_W-1:0] rows_val,
                             input bit set_cols, input logic [CFG_W-1:0] cols_val);
        quiesce();
        if ($urandom_range(0, 5) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        if (set_rows) write_reg(REG_NUM_ROWS, rows_val);
        if (set_cols) write_reg(REG_NUM_COLS, cols_val);
        cfg_valid <= 1'b0;
    endtask

    // One mesh in raster order, then its drains, with some early drains,
    // surplus points and surplus drains mixed in. A partial mesh stops early.
    task automatic run_mesh(input bit partial);
        int unsigned n_pts, n_cols, stop_at;
        n_cols = grad_check.cols;
        n_pts = grad_check.rows * n_cols;
        stop_at = partial ? $urandom_range(0, n_pts - 1) : n_pts;
        for (int i = 0; i < stop_at; i++) begin
            if ($urandom_range(0, 19) == 0) send_item(OP_DRAIN, rand_point());
            send_item(OP_POINT, rand_point());
        end
        if (!partial) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_item(OP_POINT, rand_point());
            repeat (n_cols) send_item(OP_DRAIN, rand_point());
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_item(OP_DRAIN, rand_point());
        end
    endtask

    initial begin
        logic [COORD_W-1:0] c_max, c_min, c_zero, c_ones;
        grad_check = new();
        quiet = 1'b0;
        rand_count = 0;
        idle_cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_POINT;
        cfg_valid = 1'b0;
        cfg_index = REG_NUM_ROWS;
        cfg_data = '0;
        c_max = {1'b0, {(COORD_W-1){1'b1}}};
        c_min = {1'b1, {(COORD_W-1){1'b0}}};
        c_zero = '0;
        c_ones = '1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Default 2 by 2 mesh with extreme coordinates, early and surplus drains.
        send_item(OP_DRAIN, '1);
        send_item(OP_POINT, {c_zero, c_min, c_max});
        send_item(OP_POINT, {c_ones, c_max, c_min});
        send_item(OP_DRAIN, '0);
        send_item(OP_POINT, {c_min, c_ones, c_zero});
        send_item(OP_POINT, {c_max, c_zero, c_ones});
        send_item(OP_DRAIN, '0);
        send_item(OP_DRAIN, '0);
        send_item(OP_DRAIN, '0);

        // Zero sizes act as a single point: both derivatives are zero.
        configure(1'b1, '0, 1'b1, '0);
        send_item(OP_POINT, {c_max, c_min, c_max});
        send_item(OP_DRAIN, '0);

        // Writes to unused indexes must not restart the finished mesh.
        quiesce();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '0);
        cfg_valid <= 1'b0;
        send_item(OP_POINT, rand_point());
        send_item(OP_DRAIN, rand_point());

        // 3 by 3 mesh: the middle point takes central differences both ways.
        configure(1'b1, 11'd3, 1'b1, 11'd3);
        repeat (9) send_item(OP_POINT, rand_point());
        repeat (3) send_item(OP_DRAIN, rand_point());

        // Tall single-column mesh with an oversized row count that must
        // saturate; only its first rows are sent.
        configure(1'b1, '1, 1'b1, 11'd1);
        repeat (TALL_PTS) send_item(OP_POINT, rand_point());

        // Random small meshes, mostly complete.
        while (rand_count < RAND_ITEMS) begin
            if (rand_count >= QUIET_FROM) quiet = 1'b1;
            case ($urandom_range(0, 3))
                0: configure(1'b1, CFG_W'($urandom_range(1, 6)), 1'b0, '0);
                1: configure(1'b0, '0, 1'b1, CFG_W'($urandom_range(1, 8)));
                default: begin
                    if ($urandom_range(0, 7) == 0)
                        configure(1'b1, CFG_W'($urandom_range(1, 20)),
                                  1'b1, CFG_W'($urandom_range(1, 20)));
                    else
                        configure(1'b1, CFG_W'($urandom_range(1, 6)),
                                  1'b1, CFG_W'($urandom_range(1, 8)));
                end
            endcase
            run_mesh($urandom_range(0, 9) == 0);
        end

        // Wait for the last results, then for anything stray.
        s_tvalid <= 1'b0;
        while (grad_check.pending() != 0) @(posedge aclk);
        repeat (FLUSH_CYC) @(posedge aclk);
        if (grad_check.errors == 0 && grad_check.pending() == 0)
            $display("tb_grid_finite_difference_gradient: done, clean");
        else
            $display("tb_grid_finite_difference_gradient: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hdl/gfd_pkg.sv
hdl/gfd_line_store.sv
hdl/gfd_diff.sv
hdl/grid_finite_difference_gradient.sv
sim/tb_grid_finite_difference_gradient.sv
